### design/jsfx_pkg.sv
// Shared types and constants for the JSON string field extractor.
package jsfx_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_LEN_W     = 5;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 2;
    localparam int MAX_RESULTS   = 4;
    localparam int RES_IDX_W     = 2;
    localparam int RES_CNT_W     = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_CNT_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LO  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HI  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LEN = 2'd2;

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_COMPLETE  = 2'd1;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd2;
    localparam logic [1:0] KIND_BAD       = 2'd3;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_doc;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } out_word_t;

    // All results caused by one input byte.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [MAX_RESULTS-1:0][1:0] kinds;
        logic [RES_CNT_W-1:0]        count;
    } group_t;

    typedef enum logic [6:0] {
        PH_SEARCH = 7'b0000001,
        PH_COLON  = 7'b0000010,
        PH_VALUE  = 7'b0000100,
        PH_STRING = 7'b0001000,
        PH_ESCAPE = 7'b0010000,
        PH_HEX    = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

endpackage

### design/jsfx_front.sv
// Front end: configuration registers, key matcher and string decoder, one byte per cycle on accept.
module jsfx_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [jsfx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [jsfx_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                accept,
    input  jsfx_pkg::in_word_t                  in_word,
    output logic                                group_push,
    output jsfx_pkg::group_t                    group
);

    logic [jsfx_pkg::CFG_DATA_W-1:0]    key_lo_reg;
    logic [jsfx_pkg::CFG_DATA_W-1:0]    key_hi_reg;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     key_len_reg;

    jsfx_pkg::phase_t                   phase_reg;
    jsfx_pkg::phase_t                   phase_next;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     match_count_reg;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     match_count_next;
    logic [1:0]                         hex_count_reg;
    logic [1:0]                         hex_count_next;
    logic [15:0]                        code_point_reg;
    logic [15:0]                        code_point_next;

    logic [jsfx_pkg::MAX_KEY_BYTES-1:0][7:0] key_arr;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     used_len;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     match_pos;
    logic [jsfx_pkg::KEY_LEN_W-1:0]     match_inc;
    logic [jsfx_pkg::KEY_LEN_W:0]       match_goal;
    logic [7:0]                         needle;
    logic [7:0]                         c;
    logic                               is_space;
    logic [3:0]                         hex_val;
    logic                               hex_ok;
    logic [15:0]                        cp;
    logic [jsfx_pkg::MAX_RESULTS-1:0][7:0] res_bytes;
    logic [jsfx_pkg::MAX_RESULTS-1:0][1:0] res_kinds;
    logic [jsfx_pkg::RES_CNT_W-1:0]     base_count;
    logic [jsfx_pkg::RES_CNT_W-1:0]     total_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_lo_reg  <= '0;
            key_hi_reg  <= '0;
            key_len_reg <= jsfx_pkg::KEY_LEN_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                jsfx_pkg::REG_KEY_LO:  key_lo_reg  <= cfg_data;
                jsfx_pkg::REG_KEY_HI:  key_hi_reg  <= cfg_data;
                jsfx_pkg::REG_KEY_LEN: key_len_reg <= cfg_data[jsfx_pkg::KEY_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign key_arr = {key_hi_reg, key_lo_reg};
    assign c       = in_word.in_byte;

    always_comb
    begin
        used_len = key_len_reg;
        if (key_len_reg == '0)
        begin
            used_len = jsfx_pkg::KEY_LEN_W'(1);
        end
        else if (key_len_reg > jsfx_pkg::KEY_LEN_W'(jsfx_pkg::MAX_KEY_BYTES))
        begin
            used_len = jsfx_pkg::KEY_LEN_W'(jsfx_pkg::MAX_KEY_BYTES);
        end
    end

    assign match_pos  = match_count_reg - jsfx_pkg::KEY_LEN_W'(1);
    assign match_inc  = match_count_reg + jsfx_pkg::KEY_LEN_W'(1);
    assign match_goal = {1'b0, used_len} + (jsfx_pkg::KEY_LEN_W + 1)'(2);

    always_comb
    begin
        if (match_count_reg == '0 || match_count_reg > used_len)
        begin
            needle = jsfx_pkg::CH_QUOTE;
        end
        else
        begin
            needle = key_arr[match_pos[3:0]];
        end
    end

    assign is_space = (c == jsfx_pkg::CH_SPACE) || (c == jsfx_pkg::CH_LF) ||
                      (c == jsfx_pkg::CH_CR) || (c == jsfx_pkg::CH_TAB);

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            hex_val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            hex_val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            hex_val = 4'(c - 8'h37);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign cp = {code_point_reg[11:0], hex_val};

    always_comb
    begin
        phase_next       = phase_reg;
        match_count_next = match_count_reg;
        hex_count_next   = hex_count_reg;
        code_point_next  = code_point_reg;
        res_bytes        = '0;
        res_kinds        = '0;
        base_count       = '0;

        unique case (phase_reg)
            jsfx_pkg::PH_SEARCH:
            begin
                if (c == needle)
                begin
                    if ({1'b0, match_inc} >= match_goal)
                    begin
                        match_count_next = '0;
                        phase_next       = jsfx_pkg::PH_COLON;
                    end
                    else
                    begin
                        match_count_next = match_inc;
                    end
                end
                else
                begin
                    match_count_next = (c == jsfx_pkg::CH_QUOTE) ?
                                       jsfx_pkg::KEY_LEN_W'(1) : '0;
                end
            end
            jsfx_pkg::PH_COLON:
            begin
                if (!is_space)
                begin
                    phase_next = (c == jsfx_pkg::CH_COLON) ?
                                 jsfx_pkg::PH_VALUE : jsfx_pkg::PH_SEARCH;
                    match_count_next = '0;
                end
            end
            jsfx_pkg::PH_VALUE:
            begin
                if (!is_space)
                begin
                    if (c == jsfx_pkg::CH_QUOTE)
                    begin
                        phase_next = jsfx_pkg::PH_STRING;
                    end
                    else
                    begin
                        res_kinds[0] = jsfx_pkg::KIND_BAD;
                        base_count   = jsfx_pkg::RES_CNT_W'(1);
                        phase_next   = jsfx_pkg::PH_DONE;
                    end
                end
            end
            jsfx_pkg::PH_STRING:
            begin
                if (c == jsfx_pkg::CH_QUOTE)
                begin
                    res_kinds[0] = jsfx_pkg::KIND_COMPLETE;
                    base_count   = jsfx_pkg::RES_CNT_W'(1);
                    phase_next   = jsfx_pkg::PH_DONE;
                end
                else if (c == jsfx_pkg::CH_BSLASH)
                begin
                    phase_next = jsfx_pkg::PH_ESCAPE;
                end
                else
                begin
                    res_bytes[0] = c;
                    base_count   = jsfx_pkg::RES_CNT_W'(1);
                end
            end
            jsfx_pkg::PH_ESCAPE:
            begin
                phase_next = jsfx_pkg::PH_STRING;
                base_count = jsfx_pkg::RES_CNT_W'(1);
                unique case (c) inside
                    jsfx_pkg::CH_QUOTE, jsfx_pkg::CH_BSLASH, jsfx_pkg::CH_SLASH:
                        res_bytes[0] = c;
                    jsfx_pkg::CH_LOW_B: res_bytes[0] = jsfx_pkg::CH_BS;
                    jsfx_pkg::CH_LOW_F: res_bytes[0] = jsfx_pkg::CH_FF;
                    jsfx_pkg::CH_LOW_N: res_bytes[0] = jsfx_pkg::CH_LF;
                    jsfx_pkg::CH_LOW_R: res_bytes[0] = jsfx_pkg::CH_CR;
                    jsfx_pkg::CH_LOW_T: res_bytes[0] = jsfx_pkg::CH_TAB;
                    jsfx_pkg::CH_LOW_U:
                    begin
                        base_count      = '0;
                        phase_next      = jsfx_pkg::PH_HEX;
                        hex_count_next  = '0;
                        code_point_next = '0;
                    end
                    default:
                    begin
                        res_kinds[0] = jsfx_pkg::KIND_BAD;
                        phase_next   = jsfx_pkg::PH_DONE;
                    end
                endcase
            end
            jsfx_pkg::PH_HEX:
            begin
                if (!hex_ok)
                begin
                    res_kinds[0] = jsfx_pkg::KIND_BAD;
                    base_count   = jsfx_pkg::RES_CNT_W'(1);
                    phase_next   = jsfx_pkg::PH_DONE;
                end
                else if (hex_count_reg == 2'd3)
                begin
                    hex_count_next  = '0;
                    code_point_next = '0;
                    phase_next      = jsfx_pkg::PH_STRING;
                    if (cp[15:7] == '0)
                    begin
                        res_bytes[0] = cp[7:0];
                        base_count   = jsfx_pkg::RES_CNT_W'(1);
                    end
                    else if (cp[15:11] == '0)
                    begin
                        res_bytes[0] = {3'b110, cp[10:6]};
                        res_bytes[1] = {2'b10, cp[5:0]};
                        base_count   = jsfx_pkg::RES_CNT_W'(2);
                    end
                    else
                    begin
                        res_bytes[0] = {4'b1110, cp[15:12]};
                        res_bytes[1] = {2'b10, cp[11:6]};
                        res_bytes[2] = {2'b10, cp[5:0]};
                        base_count   = jsfx_pkg::RES_CNT_W'(3);
                    end
                end
                else
                begin
                    code_point_next = cp;
                    hex_count_next  = hex_count_reg + 2'd1;
                end
            end
            default:
            begin
                phase_next = jsfx_pkg::PH_DONE;
            end
        endcase

        total_count = base_count;
        if (in_word.end_of_doc)
        begin
            if (phase_next == jsfx_pkg::PH_SEARCH || phase_next == jsfx_pkg::PH_COLON)
            begin
                res_kinds[base_count[jsfx_pkg::RES_IDX_W-1:0]] = jsfx_pkg::KIND_NOT_FOUND;
                total_count = base_count + jsfx_pkg::RES_CNT_W'(1);
            end
            else if (phase_next != jsfx_pkg::PH_DONE)
            begin
                res_kinds[base_count[jsfx_pkg::RES_IDX_W-1:0]] = jsfx_pkg::KIND_BAD;
                total_count = base_count + jsfx_pkg::RES_CNT_W'(1);
            end
            phase_next       = jsfx_pkg::PH_SEARCH;
            match_count_next = '0;
            hex_count_next   = '0;
            code_point_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= jsfx_pkg::PH_SEARCH;
            match_count_reg <= '0;
            hex_count_reg   <= '0;
            code_point_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            match_count_reg <= match_count_next;
            hex_count_reg   <= hex_count_next;
            code_point_reg  <= code_point_next;
        end
    end

    assign group_push  = accept && (total_count != '0);
    assign group.bytes = res_bytes;
    assign group.kinds = res_kinds;
    assign group.count = total_count;

endmodule

### design/jsfx_queue.sv
// Short queue of result groups between the front end and the back end.
module jsfx_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsfx_pkg::group_t   push_group,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output jsfx_pkg::group_t   head_group
);

    jsfx_pkg::group_t                  entries_reg [jsfx_pkg::QUEUE_DEPTH];
    logic [jsfx_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [jsfx_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [jsfx_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [jsfx_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = (count_reg == jsfx_pkg::QUEUE_CNT_W'(jsfx_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + jsfx_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - jsfx_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + jsfx_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + jsfx_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign head_group = entries_reg[rd_ptr_reg];

endmodule

### design/jsfx_back.sv
// Back end: hands out the results of the oldest group one word at a time.
module jsfx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 group_empty,
    input  jsfx_pkg::group_t     head_group,
    output logic                 group_pop,
    input  logic                 pop,
    output jsfx_pkg::out_word_t  out_word
);

    logic [jsfx_pkg::RES_IDX_W-1:0] idx_reg;
    logic                           last;
    logic                           take;

    assign last = ({1'b0, idx_reg} == (head_group.count - jsfx_pkg::RES_CNT_W'(1)));
    assign take = pop && !group_empty;
    assign group_pop = take && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= last ? '0 : idx_reg + jsfx_pkg::RES_IDX_W'(1);
        end
    end

    assign out_word.out_byte    = head_group.bytes[idx_reg];
    assign out_word.kind        = head_group.kinds[idx_reg];
    assign out_word.last_of_run = last;

endmodule

### design/json_string_field_extractor_unit.sv
// Top level of the JSON string field extractor.
// The block takes one document byte per cycle whenever full is low, and the key search and
// string decoding for that byte finish in the same cycle. Each byte yields zero to four result
// words, which are grouped and placed in a four-group queue; the first word of a group is
// visible on the result side once older groups have left. Words leave at one per cycle while
// pop is high, so the sustained input rate is one byte per cycle while bytes average at most
// one result, and full rises when four groups wait, which happens only when results are not
// popped as fast as they are produced. The user must write configuration registers through
// cfg_write, cfg_index and cfg_data only while the block is idle; this is not enforced.
module json_string_field_extractor_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [jsfx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [jsfx_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              push,
    output logic                              full,
    input  jsfx_pkg::in_word_t                in_word,
    output logic                              empty,
    input  logic                              pop,
    output jsfx_pkg::out_word_t               out_word
);

    logic               accept;
    logic               group_push;
    jsfx_pkg::group_t   group;
    logic               group_pop;
    jsfx_pkg::group_t   head_group;

    assign accept = push && !full;

    jsfx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .in_word    (in_word),
        .group_push (group_push),
        .group      (group)
    );

    jsfx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (group_push),
        .push_group (group),
        .full       (full),
        .pop        (group_pop),
        .empty      (empty),
        .head_group (head_group)
    );

    jsfx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .group_empty (empty),
        .head_group  (head_group),
        .group_pop   (group_pop),
        .pop         (pop),
        .out_word    (out_word)
    );

endmodule

### test/tb_json_string_field_extractor_unit.sv
// Self-checking testbench for the JSON string field extractor unit.
module tb_json_string_field_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_G = 8'h67;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [jsfx_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [jsfx_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    jsfx_pkg::in_word_t in_word = '0;
    logic empty;
    logic pop = 1'b0;
    jsfx_pkg::out_word_t out_word;

    // Register copies and decoder state of the expected behavior.
    logic [63:0] key_lo = '0;
    logic [63:0] key_hi = '0;
    logic [jsfx_pkg::KEY_LEN_W-1:0] key_len_reg = 5'd1;
    jsfx_pkg::phase_t parse_phase = jsfx_pkg::PH_SEARCH;
    logic [4:0] match_cnt = '0;
    logic [1:0] hex_cnt = '0;
    logic [15:0] code_pt = '0;

    jsfx_pkg::in_word_t pending_words[$];
    jsfx_pkg::out_word_t expected_words[$];

    int queued_items = 0;
    int accepted_items = 0;
    int docs_queued = 0;
    int words_checked = 0;
    int kind_seen[4] = '{0, 0, 0, 0};
    int full_cycles = 0;
    int errors = 0;
    int cycle_count = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_left = 0;
    bit hold_armed = 1'b0;
    bit hold_done = 1'b0;
    bit send_steady = 1'b0;
    bit recv_steady = 1'b0;

    json_string_field_extractor_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int used_key_len();
        if (key_len_reg == 0)
        begin
            return 1;
        end
        if (key_len_reg > jsfx_pkg::MAX_KEY_BYTES)
        begin
            return jsfx_pkg::MAX_KEY_BYTES;
        end
        return int'(key_len_reg);
    endfunction

    function automatic logic [7:0] needle_byte(input int pos, input int len);
        logic [127:0] key_all;
        key_all = {key_hi, key_lo};
        if (pos == 0 || pos > len)
        begin
            return jsfx_pkg::CH_QUOTE;
        end
        return key_all[8*(pos-1) +: 8];
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == jsfx_pkg::CH_SPACE || c == jsfx_pkg::CH_LF ||
               c == jsfx_pkg::CH_CR || c == jsfx_pkg::CH_TAB;
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_ZERO + 8'd9)
        begin
            return int'(c - CH_ZERO);
        end
        if (c >= CH_LOW_A && c <= CH_LOW_A + 8'd5)
        begin
            return int'(c - CH_LOW_A) + 10;
        end
        if (c >= CH_UP_A && c <= CH_UP_A + 8'd5)
        begin
            return int'(c - CH_UP_A) + 10;
        end
        return -1;
    endfunction

    function automatic void add_result(ref jsfx_pkg::out_word_t grp[$], input logic [7:0] b,
                                       input logic [1:0] k);
        if (grp.size() < jsfx_pkg::MAX_RESULTS)
        begin
            grp.push_back('{out_byte: b, kind: k, last_of_run: 1'b0});
        end
    endfunction

    // Advances the decoder by one document byte and queues the words it yields.
    function automatic void predict_results(input jsfx_pkg::in_word_t w);
        jsfx_pkg::out_word_t grp[$];
        logic [7:0] c;
        int klen;
        int nib;
        c = w.in_byte;
        klen = used_key_len();
        case (parse_phase)
            jsfx_pkg::PH_SEARCH:
            begin
                if (c == needle_byte(int'(match_cnt), klen))
                begin
                    if (int'(match_cnt) + 1 >= klen + 2)
                    begin
                        match_cnt = '0;
                        parse_phase = jsfx_pkg::PH_COLON;
                    end
                    else
                    begin
                        match_cnt = match_cnt + 1'b1;
                    end
                end
                else
                begin
                    match_cnt = (c == jsfx_pkg::CH_QUOTE) ? 5'd1 : 5'd0;
                end
            end
            jsfx_pkg::PH_COLON:
            begin
                if (!is_blank(c))
                begin
                    parse_phase = (c == jsfx_pkg::CH_COLON) ?
                                  jsfx_pkg::PH_VALUE : jsfx_pkg::PH_SEARCH;
                    match_cnt = '0;
                end
            end
            jsfx_pkg::PH_VALUE:
            begin
                if (!is_blank(c))
                begin
                    if (c == jsfx_pkg::CH_QUOTE)
                    begin
                        parse_phase = jsfx_pkg::PH_STRING;
                    end
                    else
                    begin
                        add_result(grp, 8'h00, jsfx_pkg::KIND_BAD);
                        parse_phase = jsfx_pkg::PH_DONE;
                    end
                end
            end
            jsfx_pkg::PH_STRING:
            begin
                if (c == jsfx_pkg::CH_QUOTE)
                begin
                    add_result(grp, 8'h00, jsfx_pkg::KIND_COMPLETE);
                    parse_phase = jsfx_pkg::PH_DONE;
                end
                else if (c == jsfx_pkg::CH_BSLASH)
                begin
                    parse_phase = jsfx_pkg::PH_ESCAPE;
                end
                else
                begin
                    add_result(grp, c, jsfx_pkg::KIND_DATA);
                end
            end
            jsfx_pkg::PH_ESCAPE:
            begin
                parse_phase = jsfx_pkg::PH_STRING;
                case (c)
                    jsfx_pkg::CH_QUOTE, jsfx_pkg::CH_BSLASH, jsfx_pkg::CH_SLASH:
                        add_result(grp, c, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_B:
                        add_result(grp, jsfx_pkg::CH_BS, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_F:
                        add_result(grp, jsfx_pkg::CH_FF, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_N:
                        add_result(grp, jsfx_pkg::CH_LF, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_R:
                        add_result(grp, jsfx_pkg::CH_CR, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_T:
                        add_result(grp, jsfx_pkg::CH_TAB, jsfx_pkg::KIND_DATA);
                    jsfx_pkg::CH_LOW_U:
                    begin
                        parse_phase = jsfx_pkg::PH_HEX;
                        hex_cnt = '0;
                        code_pt = '0;
                    end
                    default:
                    begin
                        add_result(grp, 8'h00, jsfx_pkg::KIND_BAD);
                        parse_phase = jsfx_pkg::PH_DONE;
                    end
                endcase
            end
            jsfx_pkg::PH_HEX:
            begin
                nib = hex_value(c);
                if (nib < 0)
                begin
                    add_result(grp, 8'h00, jsfx_pkg::KIND_BAD);
                    parse_phase = jsfx_pkg::PH_DONE;
                end
                else
                begin
                    code_pt = {code_pt[11:0], nib[3:0]};
                    if (hex_cnt == 2'd3)
                    begin
                        if (code_pt <= 16'h007F)
                        begin
                            add_result(grp, code_pt[7:0], jsfx_pkg::KIND_DATA);
                        end
                        else if (code_pt <= 16'h07FF)
                        begin
                            add_result(grp, 8'hC0 | 8'(code_pt >> 6), jsfx_pkg::KIND_DATA);
                            add_result(grp, 8'h80 | 8'(code_pt & 16'h003F),
                                       jsfx_pkg::KIND_DATA);
                        end
                        else
                        begin
                            add_result(grp, 8'hE0 | 8'(code_pt >> 12), jsfx_pkg::KIND_DATA);
                            add_result(grp, 8'h80 | 8'((code_pt >> 6) & 16'h003F),
                                       jsfx_pkg::KIND_DATA);
                            add_result(grp, 8'h80 | 8'(code_pt & 16'h003F),
                                       jsfx_pkg::KIND_DATA);
                        end
                        hex_cnt = '0;
                        code_pt = '0;
                        parse_phase = jsfx_pkg::PH_STRING;
                    end
                    else
                    begin
                        hex_cnt = hex_cnt + 1'b1;
                    end
                end
            end
            default: parse_phase = jsfx_pkg::PH_DONE;
        endcase
        if (w.end_of_doc)
        begin
            if (parse_phase == jsfx_pkg::PH_SEARCH || parse_phase == jsfx_pkg::PH_COLON)
            begin
                add_result(grp, 8'h00, jsfx_pkg::KIND_NOT_FOUND);
            end
            else if (parse_phase != jsfx_pkg::PH_DONE)
            begin
                add_result(grp, 8'h00, jsfx_pkg::KIND_BAD);
            end
            parse_phase = jsfx_pkg::PH_SEARCH;
            match_cnt = '0;
            hex_cnt = '0;
            code_pt = '0;
        end
        if (grp.size() > 0)
        begin
            grp[grp.size()-1].last_of_run = 1'b1;
        end
        foreach (grp[i])
        begin
            expected_words.push_back(grp[i]);
        end
    endfunction

    // Long calm stretches alternate with stretches of random gaps.
    function automatic int draw_gap(ref bit steady);
        if ($urandom_range(0, 15) == 0)
        begin
            steady = !steady;
        end
        return steady ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return jsfx_pkg::CH_QUOTE;
            1: return jsfx_pkg::CH_BSLASH;
            2: return jsfx_pkg::CH_COLON;
            3: return jsfx_pkg::CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CH_ZERO + 8'(nib);
        end
        return ($urandom_range(0, 1) ? CH_LOW_A : CH_UP_A) + 8'(nib) - 8'd10;
    endfunction

    task automatic push_spaces(ref logic [7:0] doc[$]);
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 3))
                0: doc.push_back(jsfx_pkg::CH_SPACE);
                1: doc.push_back(jsfx_pkg::CH_LF);
                2: doc.push_back(jsfx_pkg::CH_CR);
                default: doc.push_back(jsfx_pkg::CH_TAB);
            endcase
        end
    endtask

    task automatic queue_doc(ref logic [7:0] doc[$]);
        foreach (doc[i])
        begin
            pending_words.push_back('{in_byte: doc[i], end_of_doc: (i == doc.size() - 1)});
            queued_items++;
        end
        docs_queued++;
    endtask

    // Mostly well-formed key/value documents with random content and flaws.
    task automatic queue_random_document();
        logic [7:0] doc[$];
        logic [15:0] cp;
        logic [127:0] key_all;
        int klen;
        int key_start;
        int cut;
        int bad_pos;
        key_all = {key_hi, key_lo};
        klen = used_key_len();
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 6))
            begin
                doc.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            repeat ($urandom_range(0, 3))
            begin
                doc.push_back(noise_byte());
            end
            doc.push_back(jsfx_pkg::CH_QUOTE);
            key_start = doc.size();
            for (int i = 0; i < klen; i++)
            begin
                doc.push_back(key_all[8*i +: 8]);
            end
            if ($urandom_range(0, 7) == 0)
            begin
                doc[key_start + $urandom_range(0, klen - 1)] = 8'($urandom_range(0, 255));
            end
            doc.push_back(jsfx_pkg::CH_QUOTE);
            push_spaces(doc);
            doc.push_back(($urandom_range(0, 9) == 0) ? noise_byte() : jsfx_pkg::CH_COLON);
            push_spaces(doc);
            doc.push_back(($urandom_range(0, 9) == 0) ? noise_byte() : jsfx_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 5))
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        doc.push_back(8'($urandom_range(0, 255)));
                    end
                    2:
                    begin
                        doc.push_back(jsfx_pkg::CH_BSLASH);
                        case ($urandom_range(0, 7))
                            0: doc.push_back(jsfx_pkg::CH_QUOTE);
                            1: doc.push_back(jsfx_pkg::CH_BSLASH);
                            2: doc.push_back(jsfx_pkg::CH_SLASH);
                            3: doc.push_back(jsfx_pkg::CH_LOW_B);
                            4: doc.push_back(jsfx_pkg::CH_LOW_F);
                            5: doc.push_back(jsfx_pkg::CH_LOW_N);
                            6: doc.push_back(jsfx_pkg::CH_LOW_R);
                            default: doc.push_back(jsfx_pkg::CH_LOW_T);
                        endcase
                    end
                    3, 4:
                    begin
                        case ($urandom_range(0, 2))
                            0: cp = 16'($urandom_range(0, 16'h007F));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        endcase
                        bad_pos = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
                        doc.push_back(jsfx_pkg::CH_BSLASH);
                        doc.push_back(jsfx_pkg::CH_LOW_U);
                        for (int i = 3; i >= 0; i--)
                        begin
                            if (i == bad_pos)
                            begin
                                doc.push_back($urandom_range(0, 1) ? CH_LOW_G : noise_byte());
                            end
                            else
                            begin
                                doc.push_back(hex_char(cp[4*i +: 4]));
                            end
                        end
                    end
                    default:
                    begin
                        doc.push_back(jsfx_pkg::CH_BSLASH);
                        doc.push_back(noise_byte());
                    end
                endcase
            end
            if ($urandom_range(0, 7) != 0)
            begin
                doc.push_back(jsfx_pkg::CH_QUOTE);
            end
            repeat ($urandom_range(0, 2))
            begin
                doc.push_back(noise_byte());
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            cut = $urandom_range(1, doc.size());
            doc = doc[0:cut-1];
        end
        queue_doc(doc);
    endtask

    task automatic queue_random_bytes(input int count);
        int start;
        start = queued_items;
        while (queued_items - start < count)
        begin
            queue_random_document();
        end
    endtask

    task automatic write_reg(input logic [jsfx_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [jsfx_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            jsfx_pkg::REG_KEY_LO: key_lo = data;
            jsfx_pkg::REG_KEY_HI: key_hi = data;
            jsfx_pkg::REG_KEY_LEN: key_len_reg = data[jsfx_pkg::KEY_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (accepted_items != queued_items || expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: one document byte per word, with random gaps between words.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        bit waiting;
        if (!rst_n)
        begin
            push <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            gap = send_wait;
            waiting = push;
            if (full)
            begin
                full_cycles++;
            end
            if (push && !full)
            begin
                predict_results(in_word);
                accepted_items++;
                waiting = 1'b0;
                gap = draw_gap(send_steady);
            end
            else if (!push && gap != 0)
            begin
                gap = gap - 1;
            end
            if (!waiting)
            begin
                if (gap == 0 && pending_words.size() != 0)
                begin
                    in_word <= pending_words.pop_front();
                    push <= 1'b1;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
            send_wait <= gap;
        end
    end

    // Receiver: checks each popped word against the oldest expected word.
    always @(posedge clk or negedge rst_n)
    begin
        int gap;
        jsfx_pkg::out_word_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
            recv_wait <= 0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            gap = recv_wait;
            if (pop && !empty)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word: out_byte %h kind %0d last_of_run %0d",
                           out_word.out_byte, out_word.kind, out_word.last_of_run);
                    errors++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    words_checked++;
                    kind_seen[want.kind]++;
                    if (out_word.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, actual %h", want.out_byte,
                               out_word.out_byte);
                        errors++;
                    end
                    if (out_word.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, actual %0d", want.kind, out_word.kind);
                        errors++;
                    end
                    if (out_word.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, actual %0d", want.last_of_run,
                               out_word.last_of_run);
                        errors++;
                    end
                end
                gap = draw_gap(recv_steady);
            end
            else if (gap != 0)
            begin
                gap = gap - 1;
            end
            if (hold_armed && !hold_done)
            begin
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
                pop <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= (gap == 0);
            end
            recv_wait <= gap;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] doc[$];
        logic [63:0] text_key;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset key is a single zero byte.
        doc = '{jsfx_pkg::CH_QUOTE, 8'h00, jsfx_pkg::CH_QUOTE, jsfx_pkg::CH_TAB,
                jsfx_pkg::CH_COLON, jsfx_pkg::CH_QUOTE, 8'hFF, jsfx_pkg::CH_BSLASH,
                jsfx_pkg::CH_LOW_U, CH_ZERO, CH_ZERO + 8'd7, CH_UP_A + 8'd5,
                CH_UP_A + 8'd5, jsfx_pkg::CH_QUOTE, 8'h80};
        queue_doc(doc);
        doc = '{jsfx_pkg::CH_QUOTE, 8'h00, jsfx_pkg::CH_QUOTE, jsfx_pkg::CH_COLON,
                jsfx_pkg::CH_QUOTE, jsfx_pkg::CH_BSLASH, jsfx_pkg::CH_LOW_U,
                CH_UP_A + 8'd5, CH_LOW_A + 8'd5, CH_UP_A + 8'd5, CH_LOW_A + 8'd5};
        queue_doc(doc);
        doc = '{CH_UP_A};
        queue_doc(doc);
        wait_idle();

        write_reg(jsfx_pkg::REG_KEY_LO, {$urandom, $urandom});
        write_reg(jsfx_pkg::REG_KEY_HI, {$urandom, $urandom});
        write_reg(jsfx_pkg::REG_KEY_LEN, 64'd0);
        queue_random_bytes(40);
        wait_idle();

        write_reg(jsfx_pkg::REG_KEY_LO, {$urandom, $urandom});
        write_reg(jsfx_pkg::REG_KEY_HI, {$urandom, $urandom});
        write_reg(jsfx_pkg::REG_KEY_LEN, 64'd31);
        queue_random_bytes(55);
        wait_idle();

        for (int i = 0; i < 8; i++)
        begin
            text_key[8*i +: 8] = 8'($urandom_range(CH_LOW_A, CH_LOW_Z));
        end
        write_reg(jsfx_pkg::REG_KEY_LO, text_key);
        write_reg(jsfx_pkg::REG_KEY_LEN, 64'd3);
        hold_armed = 1'b1;
        queue_random_bytes(55);
        wait_idle();

        write_reg(jsfx_pkg::REG_KEY_LO, '1);
        write_reg(jsfx_pkg::REG_KEY_HI, '1);
        write_reg(jsfx_pkg::REG_KEY_LEN, 64'd16);
        queue_random_bytes(40);
        wait_idle();

        write_reg(jsfx_pkg::REG_KEY_LO, '0);
        write_reg(jsfx_pkg::REG_KEY_HI, '0);
        write_reg(jsfx_pkg::REG_KEY_LEN, 64'd1);
        queue_random_bytes(15);
        wait_idle();

        $display("Run covered %0d documents in %0d bytes under key lengths 0, 1, 3, 16 and 31.",
                 docs_queued, accepted_items);
        $display("Checked %0d words (%0d data, %0d complete, %0d not found, %0d bad).",
                 words_checked, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        $display("Input was held off by a full block for %0d cycles.", full_cycles);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### json_string_field_extractor_unit.f
design/jsfx_pkg.sv
design/jsfx_front.sv
design/jsfx_queue.sv
design/jsfx_back.sv
design/json_string_field_extractor_unit.sv
test/tb_json_string_field_extractor_unit.sv
